// ===== sv/rsd_pkg.sv =====
// shared types and constants for the random scan detector
// no dependencies
package rsd_pkg;

  localparam int IDX_W  = 8;
  localparam int CNT_W  = 7;
  localparam int PADDR_W = 3;

  localparam logic [5:0] WINDOW_RESET = 6'd5;
  localparam logic [4:0] LIMIT_RESET  = 5'd10;

  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_LIMIT  = 1'b1;

  typedef struct packed {
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic        is_tcp;
    logic        syn_set;
    logic [10:0] minute_stamp;
    logic [5:0]  second_stamp;
  } in_item_t;

  typedef struct packed {
    logic        scan_alert;
    logic [31:0] alert_source;
    logic        table_full_drop;
    logic        ignored_packet;
  } out_item_t;

  // counts: tcp bank0, tcp bank1, udp bank0, udp bank1
  typedef logic [3:0][CNT_W-1:0] cnt_vec_t;

  typedef struct packed {
    logic [10:0]        minute;
    logic [5:0]         second;
    logic signed [7:0]  elapsed;
    logic               tsel;
    logic               usel;
    cnt_vec_t           cnt;
  } entry_t;

  typedef struct packed {
    logic             act;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free;
    logic [IDX_W-1:0] free_idx;
    entry_t           ent;
  } tok_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic             valid;
    logic             take;
    entry_t           ent;
  } upd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EVAL,
    ST_SCAN,
    ST_ADD,
    ST_WB,
    ST_OUT
  } state_t;

endpackage

// ===== sv/random_scan_detector_core.sv =====
// random scan detector top level: tracker cell chain, destination set memory
// and the per-transaction sequencer; depends on rsd_pkg and rsd_cell
// steps after acceptance: search through the cell chain, eval for a known source, set scan
// and add for bank 0 then bank 1 (up to MAX_DESTS each), writeback, output; stalls on out_ready
// one transaction at a time, next accepted in the cycle after the result register loads;
// reset clears valid bits, config and control, no sweep
module random_scan_detector_core #(
  parameter int TRACKERS  = 16,
  parameter int MAX_DESTS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rsd_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rsd_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rsd_pkg::*;

  localparam int TIDX_W    = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
  localparam int SLOT_W    = (MAX_DESTS > 1) ? $clog2(MAX_DESTS) : 1;
  localparam int MEM_AW    = 2 + TIDX_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << MEM_AW;
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_DESTS);

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  logic [5:0] win_r;
  logic [4:0] lim_r;
  logic start_r;
  logic take_r, take_nxt;
  logic [TIDX_W-1:0] idx_r, idx_nxt;
  entry_t ent_r, ent_nxt;
  logic bank_r, bank_nxt;
  logic [SLOT_W:0] j_r, j_nxt;
  logic pend_r, pend_nxt;
  logic found_r, found_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_r;
  logic out_valid_r, out_valid_nxt;
  logic out_load;

  tok_t chain [TRACKERS+1];
  tok_t tok_head;
  upd_t upd;

  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] rd_q;
  logic [MEM_AW-1:0] rd_addr, wr_addr;
  logic mem_we;

  logic [1:0] ci;
  logic [CNT_W-1:0] n;
  logic hit_now, found_n, issue;
  logic signed [7:0] diff, e, win_s;
  logic signed [8:0] sum;
  logic [CNT_W-1:0] lim, cur_t, cur_u;
  logic alert;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LIMIT) ? {27'd0, lim_r} : {26'd0, win_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
      lim_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WINDOW) win_r <= pwdata[5:0];
      else lim_r <= pwdata[4:0];
    end
  end

  // cell chain
  always_comb begin
    tok_head     = '0;
    tok_head.act = start_r;
  end
  assign chain[0] = tok_head;

  for (genvar g = 0; g < TRACKERS; g++) begin : g_cell
    rsd_cell #(.IDX(g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .query_src (item_r.source_addr),
      .tok_in    (chain[g]),
      .upd       (upd),
      .tok_out   (chain[g+1])
    );
  end

  // destination set memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= item_r.dest_addr;
    rd_q <= mem[rd_addr];
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    take_nxt  = take_r;
    idx_nxt   = idx_r;
    ent_nxt   = ent_r;
    bank_nxt  = bank_r;
    j_nxt     = j_r;
    pend_nxt  = pend_r;
    found_nxt = found_r;
    res_nxt   = res_r;
    upd       = '0;
    mem_we    = 1'b0;
    out_load  = 1'b0;

    ci      = {!item_r.is_tcp, bank_r};
    n       = ent_r.cnt[ci];
    hit_now = pend_r && (rd_q == item_r.dest_addr);
    found_n = found_r | hit_now;
    issue   = !found_n && (CNT_W'(j_r) < n);
    rd_addr = {!item_r.is_tcp, idx_r, bank_r, j_r[SLOT_W-1:0]};
    wr_addr = {!item_r.is_tcp, idx_r, bank_r, n[SLOT_W-1:0]};

    win_s = $signed({2'b00, win_r});
    if (item_r.minute_stamp == ent_r.minute)
      diff = $signed({2'b00, item_r.second_stamp}) - $signed({2'b00, ent_r.second});
    else
      diff = win_s + 8'sd1;
    sum = {ent_r.elapsed[7], ent_r.elapsed} + {diff[7], diff};
    if (sum > 9'sd127) e = 8'sd127;
    else if (sum < -9'sd128) e = -8'sd128;
    else e = sum[7:0];

    lim   = (CNT_W'(lim_r) > MAXC) ? MAXC : CNT_W'(lim_r);
    cur_t = ent_r.cnt[{1'b0, ent_r.tsel}];
    cur_u = ent_r.cnt[{1'b1, ent_r.usel}];
    alert = !take_r && ((cur_t >= lim) || (cur_u >= lim));

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          res_nxt  = '0;
          if (in_data.is_tcp && !in_data.syn_set) begin
            res_nxt.ignored_packet = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (chain[TRACKERS].act) begin
          bank_nxt  = 1'b0;
          j_nxt     = '0;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          if (chain[TRACKERS].hit) begin
            take_nxt  = 1'b0;
            idx_nxt   = chain[TRACKERS].hit_idx[TIDX_W-1:0];
            ent_nxt   = chain[TRACKERS].ent;
            state_nxt = ST_EVAL;
          end else if (chain[TRACKERS].free) begin
            take_nxt        = 1'b1;
            idx_nxt         = chain[TRACKERS].free_idx[TIDX_W-1:0];
            ent_nxt         = '0;
            ent_nxt.minute  = item_r.minute_stamp;
            ent_nxt.second  = item_r.second_stamp;
            state_nxt       = ST_SCAN;
          end else begin
            res_nxt.table_full_drop = 1'b1;
            state_nxt = ST_OUT;
          end
        end
      end
      ST_EVAL: begin
        ent_nxt.minute = item_r.minute_stamp;
        ent_nxt.second = item_r.second_stamp;
        if (e <= win_s) begin
          ent_nxt.elapsed = e;
          if (diff == 8'sd1) begin
            if (e == win_s) ent_nxt.elapsed = 8'sd1;
            ent_nxt.tsel = !ent_r.tsel;
            ent_nxt.usel = !ent_r.usel;
            ent_nxt.cnt[{1'b0, ent_r.tsel}] = '0;
            ent_nxt.cnt[{1'b1, ent_r.usel}] = '0;
          end
        end else begin
          ent_nxt.elapsed = 8'sd0;
          ent_nxt.cnt     = '0;
        end
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        found_nxt = found_n;
        if (issue) begin
          pend_nxt = 1'b1;
          j_nxt    = j_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!found_r && n < MAXC) begin
          mem_we          = 1'b1;
          ent_nxt.cnt[ci] = n + 1'b1;
        end
        if (!bank_r) begin
          bank_nxt  = 1'b1;
          j_nxt     = '0;
          found_nxt = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        upd.we    = 1'b1;
        upd.idx   = IDX_W'(idx_r);
        upd.valid = !alert;
        upd.take  = take_r;
        upd.ent   = ent_r;
        res_nxt.scan_alert   = alert;
        res_nxt.alert_source = alert ? item_r.source_addr : 32'd0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= (state_r == ST_IDLE) && in_valid &&
                     !(in_data.is_tcp && !in_data.syn_set);
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    take_r  <= take_nxt;
    idx_r   <= idx_nxt;
    ent_r   <= ent_nxt;
    bank_r  <= bank_nxt;
    j_r     <= j_nxt;
    found_r <= found_nxt;
    res_r   <= res_nxt;
    if (out_load) out_r <= res_r;
  end

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones({out_r.scan_alert, out_r.table_full_drop,
                                out_r.ignored_packet}) <= 1)
    else $error("more than one result flag set");

  a_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.scan_alert) |-> out_r.alert_source == 32'd0)
    else $error("alert source without alert");

  a_tok_state: assert property (@(posedge clk) disable iff (!rst_n)
    chain[TRACKERS].act |-> state_r == ST_SEARCH)
    else $error("search token outside search");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> CNT_W'(j_r) <= MAXC)
    else $error("set scan past capacity");

endmodule

// ===== sv/rsd_cell.sv =====
// one tracker cell: holds one source entry and passes the search token on
// depends on rsd_pkg
module rsd_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    query_src,
  input  rsd_pkg::tok_t  tok_in,
  input  rsd_pkg::upd_t  upd,
  output rsd_pkg::tok_t  tok_out
);
  import rsd_pkg::*;

  localparam logic [IDX_W-1:0] MY = IDX_W'(IDX);

  logic        valid_r;
  logic [31:0] src_r;
  entry_t      ent_r;
  tok_t        tok_r;
  tok_t        tok_nxt;
  logic        mine;

  assign mine = upd.we && (upd.idx == MY);

  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.act) begin
      if (valid_r) begin
        if (!tok_in.hit && src_r == query_src) begin
          tok_nxt.hit     = 1'b1;
          tok_nxt.hit_idx = MY;
          tok_nxt.ent     = ent_r;
        end
      end else if (!tok_in.free) begin
        tok_nxt.free     = 1'b1;
        tok_nxt.free_idx = MY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (mine) valid_r <= upd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mine) begin
      ent_r <= upd.ent;
      if (upd.take) src_r <= query_src;
    end
  end

  assign tok_out = tok_r;

endmodule
